// File: rtl/bps_pkg.sv
// ---------------------------------------------------------------------------
// bps_pkg: shared constants for the ballistic pitch solver
// CORDIC arctangent table, gain and fixed-point limits.
// ---------------------------------------------------------------------------
package bps_pkg;

   localparam int MAX_ITERATIONS_DEF = 20;
   localparam int CORDIC_STEPS_DEF   = 18;

   localparam logic [18:0] HALF_G_Q16  = 19'd320471;
   localparam logic [29:0] CORDIC_K_Q30 = 30'd652032874;
   localparam logic signed [28:0] AIM_MAX = 29'sd134217727;
   localparam logic signed [28:0] AIM_MIN = -29'sd134217728;
   localparam logic signed [17:0] PITCH_LIMIT = 18'sd102944;
   localparam logic [5:0] SPEED_RESET = 6'd12;

   // arctangent of 2^-i, Q2.30, truncated
   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'h3243F6A8;
         5'd1:  r = 32'h1DAC6705;
         5'd2:  r = 32'h0FADBAFC;
         5'd3:  r = 32'h07F56EA6;
         5'd4:  r = 32'h03FEAB76;
         5'd5:  r = 32'h01FFD55B;
         5'd6:  r = 32'h00FFFAAA;
         5'd7:  r = 32'h007FFF55;
         5'd8:  r = 32'h003FFFEA;
         5'd9:  r = 32'h001FFFFD;
         5'd10: r = 32'h000FFFFF;
         5'd11: r = 32'h0007FFFF;
         5'd12: r = 32'h0003FFFF;
         5'd13: r = 32'h0001FFFF;
         5'd14: r = 32'h0000FFFF;
         5'd15: r = 32'h00007FFF;
         5'd16: r = 32'h00003FFF;
         5'd17: r = 32'h00001FFF;
         5'd18: r = 32'h00000FFF;
         5'd19: r = 32'h000007FF;
         5'd20: r = 32'h000003FF;
         5'd21: r = 32'h000001FF;
         5'd22: r = 32'h000000FF;
         5'd23: r = 32'h0000007F;
         5'd24: r = 32'h0000003F;
         5'd25: r = 32'h0000001F;
         5'd26: r = 32'h0000000F;
         5'd27: r = 32'h00000008;
         5'd28: r = 32'h00000004;
         5'd29: r = 32'h00000002;
         5'd30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/bps_cordic.sv
// ---------------------------------------------------------------------------
// bps_cordic: shared shift-and-add CORDIC
// One micro-rotation per cycle, vectoring (atan2) or rotation (sine) mode.
// ---------------------------------------------------------------------------
module bps_cordic
   import bps_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               vector_mode,
   input  logic signed [47:0] x_init,
   input  logic signed [47:0] y_init,
   input  logic signed [33:0] z_init,
   output logic               done,
   output logic signed [47:0] y_out,
   output logic signed [33:0] z_out
);

   localparam int SW = $clog2(CORDIC_STEPS + 1);

   logic signed [47:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic [SW-1:0]      step_ff, step_in;
   logic               run_ff, run_in, mode_ff, mode_in, done_ff, done_in;
   logic signed [47:0] dx, dy;
   logic signed [33:0] at;
   logic               up;

   // shift by the step index; the index never passes CORDIC_STEPS
   assign dx = y_ff >>> step_ff;
   assign dy = x_ff >>> step_ff;
   assign at = $signed({2'b00, atan_entry(5'(step_ff))});
   assign up = mode_ff ? (y_ff > 0) : (z_ff < 0);

   // advance one micro-rotation
   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      step_in = step_ff; run_in = run_ff; mode_in = mode_ff; done_in = 1'b0;
      if (start) begin
         x_in = x_init; y_in = y_init; z_in = z_init;
         step_in = '0; run_in = 1'b1; mode_in = vector_mode;
      end else if (run_ff) begin
         if (up == mode_ff) begin
            x_in = x_ff + dx; y_in = y_ff - dy; z_in = z_ff + at;
         end else begin
            x_in = x_ff - dx; y_in = y_ff + dy; z_in = z_ff - at;
         end
         // rotation mode rotates the other way from the branch above, for either sign of z
         if (!mode_ff && !up) begin
            x_in = x_ff - dx; y_in = y_ff + dy; z_in = z_ff - at;
         end else if (!mode_ff && up) begin
            x_in = x_ff + dx; y_in = y_ff - dy; z_in = z_ff + at;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == SW'(CORDIC_STEPS - 1)) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0; step_ff <= '0; mode_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in; step_ff <= step_in; mode_ff <= mode_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
   end

   assign done  = done_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

// File: rtl/ballistic_pitch_solver.sv
// ---------------------------------------------------------------------------
// ballistic_pitch_solver: drag-free launch pitch for a target point
// Iterates atan2 / sine over one shared CORDIC until the miss is small or MAX_ITERATIONS rounds have run.
// ---------------------------------------------------------------------------
// channel   ports                         timing
// req       start, busy, req_distance,    word taken when start && !busy
//           req_height
// rsp       rsp_valid, rsp_pitch_angle    one-cycle strobe, cannot stall
// csr       csr_write, csr_wdata          muzzle speed, written any cycle
//
// Drop term: speed^2 by a 6x6 multiply, then a 61-bit restoring divide,
// one quotient bit a cycle. Each round runs two CORDIC passes, atan2
// then sine, then the rise multiply and the aim update; busy ends after
// MAX_ITERATIONS rounds at most, earlier when the miss gets small. busy
// is high from acceptance to the result strobe. Reset is synchronous;
// it returns the speed to 12 m/s.
// ---------------------------------------------------------------------------
module ballistic_pitch_solver
   import bps_pkg::*;
#(
   parameter int MAX_ITERATIONS = MAX_ITERATIONS_DEF,
   parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [20:0]        req_distance,
   input  logic signed [21:0] req_height,
   output logic               rsp_valid,
   output logic signed [17:0] rsp_pitch_angle,
   input  logic               csr_write,
   input  logic [5:0]         csr_wdata
);

   localparam int IW = $clog2(MAX_ITERATIONS + 1);

   localparam logic [3:0] ST_IDLE = 4'd0, ST_MUL1 = 4'd1, ST_MUL2 = 4'd2,
      ST_DIV = 4'd3, ST_ATAN = 4'd4, ST_AWAIT = 4'd5, ST_SIN = 4'd6,
      ST_SWAIT = 4'd7, ST_RISE = 4'd8, ST_UPD = 4'd9, ST_OUT = 4'd10;

   logic [3:0]         st_ff, st_in;
   logic [5:0]         speed_ff;
   logic [20:0]        dist_ff;
   logic signed [21:0] hgt_ff;
   logic signed [28:0] aim_ff, aim_in;
   logic signed [33:0] ang_ff;
   logic [41:0]        d2_ff;
   logic [60:0]        num_ff;     // distance^2 * half-g, then quotient
   logic [11:0]        v2_ff;
   logic [61:0]        rem_ff;
   logic [5:0]         bit_ff;
   logic signed [31:0] drop_ff;
   logic signed [47:0] sin_ff;
   logic signed [33:0] rise_ff;
   logic [IW-1:0]      it_ff;
   logic               res_v_ff;
   logic signed [17:0] res_ff;

   logic               c_start, c_vec, c_done;
   logic signed [47:0] c_x, c_y, c_yo;
   logic signed [33:0] c_z, c_zo;

   bps_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(c_start), .vector_mode(c_vec),
      .x_init(c_x), .y_init(c_y), .z_init(c_z), .done(c_done),
      .y_out(c_yo), .z_out(c_zo)
   );

   logic [5:0]  v_eff;
   logic [61:0] rem_sh;
   logic signed [33:0] miss, mag;
   logic signed [34:0] aim_sum;
   logic signed [69:0] prod;
   logic signed [35:0] res_r;

   assign v_eff  = (speed_ff == 6'd0) ? 6'd1 : speed_ff;
   assign rem_sh = {rem_ff[60:0], num_ff[60]};
   assign c_vec  = (st_ff == ST_ATAN);
   assign c_start = (st_ff == ST_ATAN) || (st_ff == ST_SIN);
   assign c_x = (st_ff == ST_ATAN) ? $signed({19'd0, dist_ff, 8'd0})
                                   : $signed({18'd0, CORDIC_K_Q30});
   assign c_y = (st_ff == ST_ATAN) ? 48'(aim_ff) <<< 8 : 48'sd0;
   assign c_z = (st_ff == ST_ATAN) ? 34'sd0 : ang_ff;
   assign prod = $signed({1'b0, dist_ff}) * sin_ff;
   assign miss = 34'(hgt_ff) - (rise_ff - 34'(drop_ff));
   assign mag  = miss[33] ? -miss : miss;
   assign aim_sum = 35'(aim_ff) + 35'(miss);
   assign res_r = 36'(ang_ff + 34'sd8192) >>> 14;

   // sequence the rounds over the shared CORDIC
   always_comb begin
      st_in = st_ff;
      aim_in = aim_ff;
      case (st_ff)
         ST_IDLE:  if (start) st_in = ST_MUL1;
         ST_MUL1:  st_in = ST_MUL2;
         ST_MUL2:  st_in = ST_DIV;
         ST_DIV:   if (bit_ff == 6'd60) st_in = ST_ATAN;
         ST_ATAN:  st_in = ST_AWAIT;
         ST_AWAIT: if (c_done) st_in = (aim_ff == 0 && dist_ff == 0) ? ST_SIN : ST_SIN;
         ST_SIN:   st_in = ST_SWAIT;
         ST_SWAIT: if (c_done) st_in = ST_RISE;
         ST_RISE:  st_in = ST_UPD;
         ST_UPD: begin
            if (aim_sum > 35'(AIM_MAX)) aim_in = AIM_MAX;
            else if (aim_sum < 35'(AIM_MIN)) aim_in = AIM_MIN;
            else aim_in = aim_sum[28:0];
            if (44'(mag) * 44'sd1000 < 44'sd65536 ||
                it_ff == IW'(MAX_ITERATIONS - 1)) st_in = ST_OUT;
            else st_in = ST_ATAN;
         end
         ST_OUT:   st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; speed_ff <= SPEED_RESET; res_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (csr_write) speed_ff <= csr_wdata;
         res_v_ff <= (st_ff == ST_OUT);
      end
      aim_ff <= aim_in;
      case (st_ff)
         ST_IDLE: if (start) begin
            dist_ff <= req_distance; hgt_ff <= req_height;
            aim_ff <= 29'(req_height); it_ff <= '0;
         end
         ST_MUL1: begin
            d2_ff <= 42'(dist_ff) * 42'(dist_ff);
            v2_ff <= 12'(v_eff) * 12'(v_eff);
         end
         ST_MUL2: begin
            num_ff <= 61'(d2_ff) * 61'(HALF_G_Q16);
            rem_ff <= '0; bit_ff <= '0;
         end
         ST_DIV: begin
            // restoring divide: one quotient bit per cycle
            if (rem_sh >= 62'(v2_ff)) begin
               rem_ff <= rem_sh - 62'(v2_ff);
               num_ff <= {num_ff[59:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               num_ff <= {num_ff[59:0], 1'b0};
            end
            bit_ff <= bit_ff + 6'd1;
            if (bit_ff == 6'd60)
               drop_ff <= 32'((61'({num_ff[59:0], rem_sh >= 62'(v2_ff)})
                              + 61'h80000000) >> 32);
         end
         ST_AWAIT: if (c_done)
            ang_ff <= (aim_ff == 0 && dist_ff == 0) ? 34'sd0 : c_zo;
         ST_SWAIT: if (c_done) sin_ff <= c_yo;
         ST_RISE:  rise_ff <= 34'((prod + 70'sd536870912) >>> 30);
         ST_UPD:   it_ff <= it_ff + 1'b1;
         ST_OUT: begin
            if (res_r > 36'(PITCH_LIMIT)) res_ff <= PITCH_LIMIT;
            else if (res_r < -36'(PITCH_LIMIT)) res_ff <= -PITCH_LIMIT;
            else res_ff <= res_r[17:0];
         end
         default: ;
      endcase
   end

   assign busy = (st_ff != ST_IDLE);
   assign rsp_valid = res_v_ff;
   assign rsp_pitch_angle = res_ff;

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double result strobe");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("start not taken");
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= PITCH_LIMIT && rsp_pitch_angle >= -PITCH_LIMIT))
      else $error("pitch out of range");

endmodule
